>>> rtl/encd_pkg.sv
// Shared types and constants for the elastic-net coordinate descent block.
package encd_pkg;

    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 24;
    localparam int CMD_W     = 2;
    localparam int SWEEP_W   = 14;
    localparam int SIZE_W    = 7;
    localparam int ALPHA_W   = 17;
    localparam int PEN_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;
    localparam int SWEEP_CAP = 10000;
    localparam int ALPHA_ONE = 65536;

    // datapath widths
    localparam int ACC_W = 72;
    localparam int D_W   = 50;
    localparam int DEN_W = 34;
    localparam int AD_W  = 33;
    localparam int CH_W  = 33;
    localparam int DIV_W = 74;
    localparam int CNT_W = 7;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_LOAD_COV = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TGT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_DRAIN,
        ST_FETCH,
        ST_CALC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_RESULT,
        ST_WRITE,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } encd_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  n;
        logic [SWEEP_W-1:0] limit;
        logic [PEN_W-1:0]   al;
        logic [PEN_W-1:0]   ol;
        logic [PEN_W-1:0]   thr;
    } encd_cfg_t;

    typedef struct packed {
        logic               load_cov;
        logic               load_tgt;
        logic               acc_clr;
        logic               dot_rd;
        logic               dot_use;
        logic               fetch;
        logic               calc;
        logic               div_load;
        logic               div_step;
        logic               res;
        logic               coef_wr;
        logic               sweep_clr;
        logic               emit_rd;
        logic               emit_load;
        logic               emit_last;
        logic               conv;
        logic [IDX_W-1:0]   j;
        logic [IDX_W-1:0]   k;
        logic [SWEEP_W-1:0] sweeps;
    } encd_cmd_t;

    typedef struct packed {
        logic conv_hit;
        logic out_free;
    } encd_stat_t;

endpackage

>>> rtl/encd_cfg.sv
// Configuration registers with range clamping and the two penalty products.
module encd_cfg #(
    parameter int MAX_SIZE = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [encd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [encd_pkg::CFG_W-1:0]       cfg_wdata,
    output encd_pkg::encd_cfg_t              cfg
);
    import encd_pkg::*;

    logic [SIZE_W-1:0]  size_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [PEN_W-1:0]   lambda_reg;
    logic [PEN_W-1:0]   thr_reg;
    logic [SWEEP_W-1:0] limit_reg;
    logic [PEN_W-1:0]   al_reg, al_next;
    logic [PEN_W-1:0]   ol_reg, ol_next;

    logic [ALPHA_W-1:0]       a_eff;
    logic [ALPHA_W+PEN_W-1:0] al_prod, ol_prod;
    logic [SIZE_W-1:0]        n_eff;
    logic [SWEEP_W-1:0]       limit_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= SIZE_W'(64);
            alpha_reg  <= ALPHA_W'(32768);
            lambda_reg <= PEN_W'(16777216);
            thr_reg    <= PEN_W'(16777);
            limit_reg  <= SWEEP_W'(SWEEP_CAP);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIZE:   size_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_ALPHA:  alpha_reg  <= cfg_wdata[ALPHA_W-1:0];
                REG_LAMBDA: lambda_reg <= cfg_wdata[PEN_W-1:0];
                REG_THRESH: thr_reg    <= cfg_wdata[PEN_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_wdata[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        a_eff   = (alpha_reg > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_reg;
        al_prod = (ALPHA_W+PEN_W)'(a_eff) * (ALPHA_W+PEN_W)'(lambda_reg)
                  + (ALPHA_W+PEN_W)'(32768);
        ol_prod = (ALPHA_W+PEN_W)'(ALPHA_W'(ALPHA_ONE) - a_eff)
                  * (ALPHA_W+PEN_W)'(lambda_reg) + (ALPHA_W+PEN_W)'(32768);
        al_next = al_prod[16 +: PEN_W];
        ol_next = ol_prod[16 +: PEN_W];
        if (size_reg == '0)
            n_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(MAX_SIZE))
            n_eff = SIZE_W'(MAX_SIZE);
        else
            n_eff = size_reg;
        limit_eff = (limit_reg > SWEEP_W'(SWEEP_CAP)) ? SWEEP_W'(SWEEP_CAP) : limit_reg;
    end

    always_ff @(posedge aclk) begin
        al_reg <= al_next;
        ol_reg <= ol_next;
    end

    assign cfg.n     = n_eff;
    assign cfg.limit = limit_eff;
    assign cfg.al    = al_reg;
    assign cfg.ol    = ol_reg;
    assign cfg.thr   = thr_reg;

endmodule

>>> rtl/encd_ctrl.sv
// Sequencer for loads, coordinate sweeps, convergence check and result output.
module encd_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [encd_pkg::CMD_W-1:0]   s_cmd,
    input  encd_pkg::encd_cfg_t          cfg,
    input  encd_pkg::encd_stat_t         stat,
    output encd_pkg::encd_cmd_t          cmd
);
    import encd_pkg::*;

    encd_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SWEEP_W-1:0] sweeps_reg, sweeps_next;
    logic               conv_reg, conv_next;

    logic j_last, k_last, accept;

    assign j_last = {1'b0, j_reg} == (cfg.n - SIZE_W'(1));
    assign k_last = {1'b0, k_reg} == (cfg.n - SIZE_W'(1));
    assign accept = (state_reg == ST_IDLE) && s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            j_reg      <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            sweeps_reg <= '0;
            conv_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            sweeps_reg <= sweeps_next;
            conv_reg   <= conv_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept && s_cmd == CMD_SOLVE) state_next = ST_DOT;
            ST_DOT:      if (k_last) state_next = ST_DRAIN;
            ST_DRAIN:    state_next = ST_FETCH;
            ST_FETCH:    state_next = ST_CALC;
            ST_CALC:     state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV:      if (cnt_reg == CNT_W'(DIV_W - 1)) state_next = ST_RESULT;
            ST_RESULT:   state_next = ST_WRITE;
            ST_WRITE:    state_next = j_last ? ST_CHECK : ST_DOT;
            ST_CHECK: begin
                if (stat.conv_hit || sweeps_reg > cfg.limit)
                    state_next = ST_EMIT_RD;
                else
                    state_next = ST_DOT;
            end
            ST_EMIT_RD:  state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (stat.out_free) state_next = j_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb begin
        j_next      = j_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        sweeps_next = sweeps_reg;
        conv_next   = conv_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_cmd == CMD_SOLVE) begin
                    j_next      = '0;
                    k_next      = '0;
                    sweeps_next = '0;
                end
            end
            ST_DOT:      if (!k_last) k_next = k_reg + IDX_W'(1);
            ST_DIV_LOAD: cnt_next = '0;
            ST_DIV:      cnt_next = cnt_reg + CNT_W'(1);
            ST_WRITE: begin
                if (j_last) begin
                    sweeps_next = sweeps_reg + SWEEP_W'(1);
                end else begin
                    j_next = j_reg + IDX_W'(1);
                    k_next = '0;
                end
            end
            ST_CHECK: begin
                j_next    = '0;
                k_next    = '0;
                conv_next = stat.conv_hit;
            end
            ST_EMIT_LD:  if (stat.out_free && !j_last) j_next = j_reg + IDX_W'(1);
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.j        = j_reg;
        cmd.k        = k_reg;
        cmd.sweeps   = sweeps_reg;
        cmd.conv     = conv_reg;
        cmd.emit_last = j_last;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_cov  = accept && s_cmd == CMD_LOAD_COV;
                cmd.load_tgt  = accept && s_cmd == CMD_LOAD_TGT;
                cmd.sweep_clr = accept && s_cmd == CMD_SOLVE;
            end
            ST_DOT: begin
                cmd.dot_rd  = 1'b1;
                cmd.dot_use = k_reg != j_reg;
                cmd.acc_clr = k_reg == '0;
            end
            ST_FETCH:    cmd.fetch = 1'b1;
            ST_CALC:     cmd.calc = 1'b1;
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_RESULT:   cmd.res = 1'b1;
            ST_WRITE:    cmd.coef_wr = 1'b1;
            ST_CHECK:    cmd.sweep_clr = 1'b1;
            ST_EMIT_RD:  cmd.emit_rd = 1'b1;
            ST_EMIT_LD:  cmd.emit_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

>>> rtl/encd_dp.sv
// Stores, multiply-accumulate pipe, restoring divider and result register.
module encd_dp #(
    parameter int MAX_SIZE   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [encd_pkg::IDX_W-1:0]      row_index,
    input  logic [encd_pkg::IDX_W-1:0]      col_index,
    input  logic signed [encd_pkg::VAL_W-1:0] load_value,
    input  logic signed [encd_pkg::VAL_W-1:0] start_coef,
    input  encd_pkg::encd_cfg_t             cfg,
    input  encd_pkg::encd_cmd_t             cmd,
    output encd_pkg::encd_stat_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [encd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import encd_pkg::*;

    localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int CAW   = $clog2(DEPTH);
    localparam int HELD  = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int QW    = HELD + 1;
    localparam longint HMAX_L = (longint'(1) <<< (HELD - 1)) - 1;
    localparam logic signed [VAL_W-1:0] HMAX = VAL_W'(HMAX_L);
    localparam logic signed [VAL_W-1:0] HMIN = -HMAX - VAL_W'(1);
    localparam logic [QW-1:0] CAP  = QW'(1) << (HELD - 1);
    localparam logic [QW-1:0] QMAX = CAP - QW'(1);

    function automatic logic signed [VAL_W-1:0] sat_held(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > HMAX)      r = HMAX;
        else if (v < HMIN) r = HMIN;
        else               r = v;
        return r;
    endfunction

    logic signed [VAL_W-1:0] cov_mem  [DEPTH];
    logic signed [VAL_W-1:0] tgt_mem  [MAX_SIZE];
    logic signed [VAL_W-1:0] coef_mem [MAX_SIZE];

    logic signed [VAL_W-1:0] cov_q, coef_q, tgt_q;
    logic                    v1_reg, v2_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [D_W-1:0]   d_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic signed [VAL_W-1:0] old_reg;
    logic [AD_W-1:0]         ad_reg;
    logic [AD_W-1:0]         rem_reg;
    logic [DIV_W-1:0]        dvd_reg;
    logic [QW-1:0]           q_reg;
    logic                    ovf_reg, small_reg, zden_reg, neg_reg;
    logic signed [VAL_W-1:0] nv_reg;
    logic [CH_W-1:0]         maxc_reg;

    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg;
    logic                    out_last_reg;

    logic row_ok, col_ok;
    logic [CAW-1:0] cov_wa, cov_ra;
    logic [AW-1:0]  coef_ra, coef_wa;
    logic signed [VAL_W-1:0] coef_wd;
    logic coef_we;

    assign row_ok = {1'b0, row_index} < SIZE_W'(MAX_SIZE);
    assign col_ok = {1'b0, col_index} < SIZE_W'(MAX_SIZE);

    always_comb begin
        cov_wa  = CAW'(int'(row_index) * MAX_SIZE + int'(col_index));
        cov_ra  = cmd.dot_rd ? CAW'(int'(cmd.j) * MAX_SIZE + int'(cmd.k))
                             : CAW'(int'(cmd.j) * MAX_SIZE + int'(cmd.j));
        coef_ra = cmd.dot_rd ? cmd.k[AW-1:0] : cmd.j[AW-1:0];
        coef_we = (cmd.load_tgt && row_ok) || cmd.coef_wr;
        coef_wa = cmd.coef_wr ? cmd.j[AW-1:0] : row_index[AW-1:0];
        coef_wd = cmd.coef_wr ? nv_reg : sat_held(start_coef);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_cov && row_ok && col_ok) cov_mem[cov_wa] <= sat_held(load_value);
        if (cmd.dot_rd || cmd.fetch)          cov_q <= cov_mem[cov_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_tgt && row_ok) tgt_mem[row_index[AW-1:0]] <= sat_held(load_value);
        if (cmd.fetch)              tgt_q <= tgt_mem[cmd.j[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (coef_we) coef_mem[coef_wa] <= coef_wd;
        if (cmd.dot_rd || cmd.fetch || cmd.emit_rd) coef_q <= coef_mem[coef_ra];
    end

    // multiply-accumulate: read, product, sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.dot_rd && cmd.dot_use;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= cov_q * coef_q;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // coordinate update
    logic signed [ACC_W-1:0] c_full;
    logic [D_W-1:0]          mag;
    logic [AD_W-1:0]         ad;
    logic [D_W-1:0]          num;
    logic [AD_W:0]           rem_sh;
    logic                    ge;
    logic [QW-1:0]           m_sel;
    logic signed [QW:0]      nv_w;
    logic signed [VAL_W:0]   ch_w;
    logic [CH_W-1:0]         ch;

    always_comb begin
        c_full = (acc_reg + (ACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        mag    = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);
        ad     = den_reg[DEN_W-1] ? AD_W'(-den_reg) : AD_W'(den_reg);
        num    = mag - D_W'(cfg.al);
        rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, ad_reg};
        if (zden_reg || ovf_reg || q_reg > CAP) m_sel = CAP;
        else                                     m_sel = q_reg;
        if (small_reg)    nv_w = '0;
        else if (neg_reg) nv_w = -$signed({1'b0, m_sel});
        else              nv_w = $signed({1'b0, (m_sel > QMAX) ? QMAX : m_sel});
        ch_w = $signed({nv_reg[VAL_W-1], nv_reg}) - $signed({old_reg[VAL_W-1], old_reg});
        ch   = ch_w[VAL_W] ? CH_W'(-ch_w) : CH_W'(ch_w);
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            d_reg   <= D_W'(tgt_q) - D_W'(c_full);
            den_reg <= DEN_W'(cov_q) + $signed(DEN_W'(cfg.ol));
            old_reg <= coef_q;
        end
        if (cmd.div_load) begin
            ad_reg    <= ad;
            small_reg <= mag <= D_W'(cfg.al);
            zden_reg  <= den_reg == '0;
            neg_reg   <= (den_reg == '0) ? d_reg[D_W-1] : (d_reg[D_W-1] ^ den_reg[DEN_W-1]);
            dvd_reg   <= (DIV_W'(num) << FRAC_W) + DIV_W'(ad >> 1);
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? AD_W'(rem_sh - {1'b0, ad_reg}) : AD_W'(rem_sh);
            q_reg   <= {q_reg[QW-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[QW-1];
            dvd_reg <= dvd_reg << 1;
        end
        if (cmd.res) nv_reg <= VAL_W'(nv_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.sweep_clr)
            maxc_reg <= '0;
        else if (cmd.coef_wr && ch > maxc_reg)
            maxc_reg <= ch;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_data_reg <= M_DATA_W'({cmd.conv, cmd.sweeps, coef_q, cmd.j});
            out_last_reg <= cmd.emit_last;
        end
    end

    assign stat.conv_hit = maxc_reg <= CH_W'(cfg.thr);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/elastic_net_coordinate_descent.sv
// Top level of the elastic-net coordinate descent solver.
// Load requests (covariance entry, or target plus start coefficient) are taken one per
// cycle while idle; no new request is taken while a solve runs. A solve request runs sweeps
// over the n active coordinates; each one passes through the one-term-per-cycle
// multiply-accumulate pipe and then the bit-serial restoring divider, and each sweep ends
// with a convergence check. The coefficients are then emitted one by one, and the output
// can stall them.
// The stores need no clearing after reset; entries must be loaded before a solve reads them.
module elastic_net_coordinate_descent #(
    parameter int MAX_SIZE   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row_index[5:0], col_index[11:6], load_value[43:12], start_coef[75:44]
    input  logic [encd_pkg::S_DATA_W-1:0]      s_tdata,
    // cmd[1:0]
    input  logic [encd_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // coef_index[5:0], coef_value[37:6], sweeps_done[51:38], converged[52]
    output logic [encd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [encd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [encd_pkg::CFG_W-1:0]         cfg_wdata
);
    import encd_pkg::*;

    encd_cfg_t  cfg;
    encd_cmd_t  cmd;
    encd_stat_t stat;

    encd_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    encd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .cfg      (cfg),
        .stat     (stat),
        .cmd      (cmd)
    );

    encd_dp #(.MAX_SIZE(MAX_SIZE), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .row_index  (s_tdata[5:0]),
        .col_index  (s_tdata[11:6]),
        .load_value ($signed(s_tdata[43:12])),
        .start_coef ($signed(s_tdata[75:44])),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // store loads only come from accepted load requests
    a_load_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_cov || cmd.load_tgt) |-> (s_tvalid && s_tready))
        else $error("store written without an accepted request");

    // the coefficient read port serves one user per cycle
    a_coef_port: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.dot_rd, cmd.fetch, cmd.emit_rd}))
        else $error("coefficient read port conflict");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the elastic-net coordinate descent solver.
`timescale 1ns / 1ps

module tb_top;
    import encd_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   value;
        logic [SWEEP_W-1:0] sweeps;
        logic               conv;
        logic               last;
    } coef_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    // local copy of the solver state and registers
    longint cov_mem [64][64];
    longint tgt_mem [64];
    longint coef_mem [64];
    int unsigned size_reg, alpha_reg, lambda_reg, thresh_reg, limit_reg;

    coef_result_t coef_q [$];
    int  err_cnt;
    int  items_sent;
    int  hold_len;
    bit  stall_en;

    elastic_net_coordinate_descent i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // soft threshold and divide, rounded half away from zero, saturated to 32 bits
    function automatic longint shrink_coef(longint d, longint den, longint al);
        longint unsigned mag, num, ad, ip, rem, m;
        bit neg;
        mag = (d < 0) ? -d : d;
        if (mag <= al) return 0;
        num = mag - al;
        if (den == 0) begin
            m   = 64'h8000_0000;
            neg = d < 0;
        end else begin
            ad  = (den < 0) ? -den : den;
            ip  = num / ad;
            rem = num % ad;
            neg = (d < 0) != (den < 0);
            if (ip > 127) begin
                m = 64'h8000_0000;
            end else begin
                m = (ip << 24) + (((rem << 24) + ad / 2) / ad);
                if (m > 64'h8000_0000) m = 64'h8000_0000;
            end
        end
        if (neg) return -longint'(m);
        return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(m);
    endfunction

    task automatic predict_solve();
        int unsigned n, a, lim, sweeps;
        longint al, ol, hs, ls, p, lo, c, nv, old;
        longint unsigned mc, ch;
        bit conv;
        coef_result_t r;
        n   = (size_reg < 1) ? 1 : (size_reg > 64) ? 64 : size_reg;
        a   = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        lim = (limit_reg > SWEEP_CAP) ? SWEEP_CAP : limit_reg;
        al  = (longint'(a) * lambda_reg + 32768) >> 16;
        ol  = (longint'(ALPHA_ONE - a) * lambda_reg + 32768) >> 16;
        sweeps = 0;
        conv   = 0;
        forever begin
            mc = 0;
            for (int j = 0; j < n; j++) begin
                hs = 0;
                ls = 0;
                for (int k = 0; k < n; k++) begin
                    if (k != j) begin
                        p  = cov_mem[j][k] * coef_mem[k];
                        lo = p & 64'hFF_FFFF;
                        hs += (p - lo) >>> 24;
                        ls += lo;
                    end
                end
                c   = hs + ((ls + (1 << 23)) >>> 24);
                old = coef_mem[j];
                nv  = shrink_coef(tgt_mem[j] - c, cov_mem[j][j] + ol, al);
                coef_mem[j] = nv;
                ch = (nv > old) ? nv - old : old - nv;
                if (ch > mc) mc = ch;
            end
            sweeps++;
            if (mc <= thresh_reg) begin
                conv = 1;
                break;
            end
            if (sweeps - 1 >= lim) break;
        end
        for (int j = 0; j < n; j++) begin
            r.idx    = j;
            r.value  = coef_mem[j][31:0];
            r.sweeps = sweeps;
            r.conv   = conv;
            r.last   = (j + 1 == n);
            coef_q.push_back(r);
        end
    endtask

    task automatic send_request(logic [CMD_W-1:0] cmd, int row, int col,
                                logic [31:0] lv, logic [31:0] sc, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, sc, lv, 6'(col), 6'(row)};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        case (cmd)
            CMD_LOAD_COV: cov_mem[row][col] = longint'(signed'(lv));
            CMD_LOAD_TGT: begin
                tgt_mem[row]  = longint'(signed'(lv));
                coef_mem[row] = longint'(signed'(sc));
            end
            CMD_SOLVE: predict_solve();
            default: ;
        endcase
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SIZE:   size_reg   = val & 32'h7F;
            REG_ALPHA:  alpha_reg  = val & 32'h1FFFF;
            REG_LAMBDA: lambda_reg = val & 32'h7FFF_FFFF;
            REG_THRESH: thresh_reg = val & 32'h7FFF_FFFF;
            REG_LIMIT:  limit_reg  = val & 32'h3FFF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (coef_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value(bit diag);
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return diag ? 32'h0 : 32'h8000_0000;
            default: return diag ? $urandom_range(32'h0080_0000, 32'h0400_0000)
                                 : 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
        endcase
    endfunction

    // fill every entry an n-size solve reads
    task automatic load_problem(int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++)
                send_request(CMD_LOAD_COV, r, c, rand_value(r == c), $urandom());
            send_request(CMD_LOAD_TGT, r, $urandom_range(0, 63), rand_value(0), rand_value(0));
        end
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_request(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom(), $urandom());
        else
            send_request($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom(), $urandom());
    endtask

    // one coordinate: second sweep never moves, so even the largest limit ends fast
    task automatic test_single_coord();
        set_reg(REG_SIZE, 1);
        set_reg(REG_LIMIT, 16383);
        set_reg(REG_THRESH, 0);
        send_request(CMD_LOAD_COV, 0, 0, 32'h0100_0000, 0);
        send_request(CMD_LOAD_TGT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        send_request(CMD_LOAD_TGT, 0, 63, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_SOLVE, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
        // zero denominator: diagonal zero with the penalty all on the lasso side
        set_reg(REG_SIZE, 0);
        set_reg(REG_ALPHA, 131071);
        set_reg(REG_LIMIT, 10000);
        send_request(CMD_LOAD_COV, 0, 0, 0, 0);
        send_request(CMD_LOAD_TGT, 0, 0, 32'h0300_0000, 0);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        send_request(CMD_LOAD_TGT, 0, 0, 32'hF000_0000, 0);
        send_request(CMD_UNUSED, 0, 0, 0, 0);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
    endtask

    task automatic test_penalty_extremes();
        set_reg(REG_SIZE, 3);
        set_reg(REG_LIMIT, 3);
        set_reg(REG_THRESH, 32'h7FFF_FFFF);
        set_reg(REG_ALPHA, 0);
        set_reg(REG_LAMBDA, 0);
        load_problem(3);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
        set_reg(REG_THRESH, 0);
        set_reg(REG_ALPHA, ALPHA_ONE);
        set_reg(REG_LAMBDA, 32'h7FFF_FFFF);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
        set_reg(REG_LIMIT, 0);
        set_reg(REG_ALPHA, 32768);
        set_reg(REG_LAMBDA, 32'h0080_0000);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
    endtask

    // larger problem: a single sweep, then one extra sweep allowed
    task automatic test_large_size();
        set_reg(REG_SIZE, 8);
        set_reg(REG_LIMIT, 0);
        load_problem(8);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
        set_reg(REG_LIMIT, 1);
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        wait_idle();
    endtask

    // receiver holds off while requests keep coming, then the sender waits for drain
    task automatic test_backpressure();
        set_reg(REG_SIZE, 4);
        set_reg(REG_LIMIT, 2);
        load_problem(4);
        hold_len = 300;
        send_request(CMD_SOLVE, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++) send_noise();
        send_request(CMD_SOLVE, 0, 0, 0, 0, 1);
        send_request(CMD_LOAD_TGT, 1, 0, rand_value(0), rand_value(0), 1);
        send_request(CMD_SOLVE, 0, 0, 0, 0, 1);
        wait_idle();
    endtask

    task automatic test_random();
        int n, stop_at;
        stop_at = items_sent + 250;
        while (items_sent < stop_at) begin
            stall_en = $urandom_range(0, 3) != 0;
            n = $urandom_range(1, 6);
            set_reg(REG_SIZE, n);
            set_reg(REG_ALPHA, $urandom_range(0, 70000));
            set_reg(REG_LAMBDA, $urandom_range(0, 32'h0300_0000));
            set_reg(REG_THRESH, $urandom_range(0, 32'h0010_0000));
            set_reg(REG_LIMIT, $urandom_range(0, 4));
            load_problem(n);
            for (int s = $urandom_range(1, 3); s > 0; s--) begin
                for (int i = $urandom_range(0, 3); i > 0; i--) begin
                    if ($urandom_range(0, 2) == 0) send_noise();
                    else send_request(CMD_LOAD_TGT, $urandom_range(0, n - 1), 0,
                                      rand_value(0), rand_value(0));
                end
                send_request(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom(), $urandom());
            end
            wait_idle();
        end
        stall_en = 1;
    endtask

    // result side: random stalls, plus an occasional long hold-off
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            w = stall_en ? $urandom_range(0, 3) : 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        coef_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (coef_q.size() == 0) begin
                $error("coefficient result with nothing expected: %h", m_tdata);
                err_cnt++;
            end else begin
                e = coef_q.pop_front();
                if (m_tdata[5:0] !== e.idx) begin
                    $error("coef_index exp %0d got %0d", e.idx, m_tdata[5:0]);
                    err_cnt++;
                end
                if (m_tdata[37:6] !== e.value) begin
                    $error("coef_value exp %h got %h", e.value, m_tdata[37:6]);
                    err_cnt++;
                end
                if (m_tdata[51:38] !== e.sweeps) begin
                    $error("sweeps_done exp %0d got %0d", e.sweeps, m_tdata[51:38]);
                    err_cnt++;
                end
                if (m_tdata[52] !== e.conv) begin
                    $error("converged exp %0b got %0b", e.conv, m_tdata[52]);
                    err_cnt++;
                end
                if (m_tlast !== e.last) begin
                    $error("last exp %0b got %0b", e.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        err_cnt    = 0;
        items_sent = 0;
        hold_len   = 0;
        stall_en   = 1;
        size_reg   = 64;
        alpha_reg  = 32768;
        lambda_reg = 32'h0100_0000;
        thresh_reg = 16777;
        limit_reg  = SWEEP_CAP;
        foreach (cov_mem[r, c]) cov_mem[r][c] = 0;
        foreach (tgt_mem[r]) begin
            tgt_mem[r]  = 0;
            coef_mem[r] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_coord();
        test_penalty_extremes();
        test_backpressure();
        test_large_size();
        test_random();

        wait_idle();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0 && coef_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
